@@ design/lrufr_pkg.sv @@
package lrufr_pkg;

  localparam int NUM_FRAMES_DEF = 64;
  localparam int FRAME_W        = 6;
  localparam int COUNT_W        = 7;
  localparam int MAX_ADDR_FRAMES = 1 << FRAME_W;

  localparam logic [COUNT_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [1:0] {
    CMD_PIN    = 2'd0,
    CMD_UNPIN  = 2'd1,
    CMD_VICTIM = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_NOCHG  = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_COMMIT
  } fsm_t;

endpackage

@@ design/lrufr_if.sv @@
interface lrufr_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     command;
  logic [lrufr_pkg::FRAME_W-1:0]  frame_num;

  modport source (output valid, output command, output frame_num, input ready);
  modport sink   (input valid, input command, input frame_num, output ready);
endinterface

interface lrufr_out_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     status;
  logic [lrufr_pkg::FRAME_W-1:0]  victim_frame;
  logic [lrufr_pkg::COUNT_W-1:0]  count;

  modport source (output valid, output status, output victim_frame, output count, input ready);
  modport sink   (input valid, input status, input victim_frame, input count, output ready);
endinterface

@@ design/lrufr_ram.sv @@
module lrufr_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/lru_frame_replacer_unit.sv @@
// LRU frame replacer. Holds the evictable frames oldest first in a doubly
// linked list kept in two link RAMs (previous and next), with a membership
// bit per frame, head, tail and count in flops. Commands: pin removes a
// frame, unpin appends it at the tail (refused when already present or the
// count has reached cfg capacity), victim removes and returns the head.
// Each command beat yields exactly one result beat with status, evicted
// frame and the count after the command. The link RAMs are read in the
// accept cycle (IDLE) and the neighbor links are written back on commit in
// the COMMIT state; no new command is accepted until the FSM is back in
// IDLE. A result may wait on the output while the next command is accepted;
// the commit stalls only if the previous result is still unread.
module lru_frame_replacer_unit #(
  parameter int NUM_FRAMES = lrufr_pkg::NUM_FRAMES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  lrufr_in_if.sink                      in_ch,
  lrufr_out_if.source                   out_ch,
  input  logic                          cfg_we,
  input  logic [lrufr_pkg::COUNT_W-1:0] cfg_wdata
);

  localparam int DEPTH = (NUM_FRAMES < lrufr_pkg::MAX_ADDR_FRAMES) ?
                         NUM_FRAMES : lrufr_pkg::MAX_ADDR_FRAMES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = lrufr_pkg::COUNT_W;
  localparam int FW    = lrufr_pkg::FRAME_W;

  lrufr_pkg::fsm_t state_r, state_nxt;

  logic [CW-1:0]    capacity_r;
  logic [DEPTH-1:0] present_r, present_nxt;
  logic [AW-1:0]    head_r, head_nxt;
  logic [AW-1:0]    tail_r, tail_nxt;
  logic [CW-1:0]    held_r, held_nxt;

  lrufr_pkg::cmd_t  cmd_r;
  logic [FW-1:0]    frame_r;

  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [FW-1:0]    out_victim_r, out_victim_nxt;
  logic [CW-1:0]    out_count_r, out_count_nxt;

  logic             accept;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    prev_q, next_q;
  logic             nx_we, pv_we;
  logic [AW-1:0]    nx_waddr, nx_wdata, pv_waddr, pv_wdata;

  logic             frame_ok;
  logic [AW-1:0]    fa;
  logic [AW-1:0]    uf;
  logic             do_unlink, do_append;
  logic             commit;

  assign in_ch.ready = (state_r == lrufr_pkg::FSM_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign rd_en       = accept;
  assign rd_addr     = (lrufr_pkg::cmd_t'(in_ch.command) == lrufr_pkg::CMD_VICTIM) ?
                       head_r : in_ch.frame_num[AW-1:0];

  lrufr_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_next_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (next_q)
  );

  lrufr_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_prev_ram (
    .clk   (clk),
    .we    (pv_we),
    .waddr (pv_waddr),
    .wdata (pv_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (prev_q)
  );

  assign frame_ok = int'(frame_r) < NUM_FRAMES;
  assign fa       = frame_r[AW-1:0];
  assign commit   = (state_r == lrufr_pkg::FSM_COMMIT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt      = state_r;
    present_nxt    = present_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    held_nxt       = held_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_victim_nxt = out_victim_r;
    out_count_nxt  = out_count_r;
    nx_we          = 1'b0;
    nx_waddr       = '0;
    nx_wdata       = '0;
    pv_we          = 1'b0;
    pv_waddr       = '0;
    pv_wdata       = '0;
    do_unlink      = 1'b0;
    do_append      = 1'b0;
    uf             = fa;

    unique case (state_r)
      lrufr_pkg::FSM_IDLE: begin
        if (accept) begin
          state_nxt = lrufr_pkg::FSM_COMMIT;
        end
      end
      lrufr_pkg::FSM_COMMIT: begin
        if (commit) begin
          state_nxt      = lrufr_pkg::FSM_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = lrufr_pkg::ST_NOCHG;
          out_victim_nxt = '0;
          case (cmd_r)
            lrufr_pkg::CMD_PIN: begin
              if (frame_ok && present_r[fa]) begin
                do_unlink      = 1'b1;
                out_status_nxt = lrufr_pkg::ST_DONE;
              end
            end
            lrufr_pkg::CMD_UNPIN: begin
              if (frame_ok && !present_r[fa]) begin
                if (held_r >= capacity_r) begin
                  out_status_nxt = lrufr_pkg::ST_FULL;
                end else begin
                  do_append      = 1'b1;
                  out_status_nxt = lrufr_pkg::ST_DONE;
                end
              end
            end
            lrufr_pkg::CMD_VICTIM: begin
              if (held_r == '0) begin
                out_status_nxt = lrufr_pkg::ST_EMPTY;
              end else begin
                uf             = head_r;
                do_unlink      = 1'b1;
                out_status_nxt = lrufr_pkg::ST_DONE;
                out_victim_nxt = FW'(head_r);
              end
            end
            default: ;
          endcase

          if (do_unlink) begin
            if (held_r <= CW'(1)) begin
              head_nxt = '0;
              tail_nxt = '0;
            end else begin
              if (uf == head_r) begin
                head_nxt = next_q;
              end else begin
                nx_we    = 1'b1;
                nx_waddr = prev_q;
                nx_wdata = next_q;
              end
              if (uf == tail_r) begin
                tail_nxt = prev_q;
              end else begin
                pv_we    = 1'b1;
                pv_waddr = next_q;
                pv_wdata = prev_q;
              end
            end
            present_nxt[uf] = 1'b0;
            held_nxt        = held_r - CW'(1);
          end

          if (do_append) begin
            if (held_r == '0) begin
              head_nxt = fa;
            end else begin
              nx_we    = 1'b1;
              nx_waddr = tail_r;
              nx_wdata = fa;
            end
            pv_we           = 1'b1;
            pv_waddr        = fa;
            pv_wdata        = tail_r;
            tail_nxt        = fa;
            present_nxt[fa] = 1'b1;
            held_nxt        = held_r + CW'(1);
          end

          out_count_nxt = held_nxt;
        end
      end
      default: state_nxt = lrufr_pkg::FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrufr_pkg::FSM_IDLE;
      capacity_r  <= lrufr_pkg::CAP_RESET;
      present_r   <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      present_r   <= present_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        capacity_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= lrufr_pkg::cmd_t'(in_ch.command);
      frame_r <= in_ch.frame_num;
    end
    out_status_r <= out_status_nxt;
    out_victim_r <= out_victim_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.victim_frame = out_victim_r;
  assign out_ch.count        = out_count_r;

  a_count_matches_members: assert property (
    @(posedge clk) disable iff (!rst_n)
    $countones(present_r) == int'(held_r)
  ) else $error("member bits disagree with count");

  a_empty_list_zero_ends: assert property (
    @(posedge clk) disable iff (!rst_n)
    (held_r == '0) |-> (head_r == '0) && (tail_r == '0)
  ) else $error("empty list with nonzero head or tail");

  a_result_from_commit: assert property (
    @(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == lrufr_pkg::FSM_COMMIT)
  ) else $error("result raised outside commit");

  a_single_member_ends: assert property (
    @(posedge clk) disable iff (!rst_n)
    (held_r == CW'(1)) |-> (head_r == tail_r) && present_r[head_r]
  ) else $error("single member list has inconsistent ends");

endmodule

@@ sim/tb_lru_frame_replacer_unit.sv @@
module tb_lru_frame_replacer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import lrufr_pkg::*;

  localparam int FRAMES    = NUM_FRAMES_DEF;
  localparam int PH_ITEMS  = 130;
  localparam int STALL_AT  = 300;
  localparam int STALL_LEN = 400;
  localparam int WDOG_MAX  = 5000;

  typedef struct packed {
    cmd_t             cmd;
    logic [FRAME_W-1:0] frame;
  } lru_cmd_t;

  typedef struct packed {
    status_t            status;
    logic [FRAME_W-1:0] victim;
    logic [COUNT_W-1:0] count;
  } lru_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;

  lrufr_in_if  in_if ();
  lrufr_out_if out_if ();

  lru_frame_replacer_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // shadow of the replacer state
  bit                 lru_present [FRAMES];
  logic [FRAME_W-1:0] lru_next [FRAMES];
  logic [FRAME_W-1:0] lru_prev [FRAMES];
  logic [FRAME_W-1:0] lru_head = '0;
  logic [FRAME_W-1:0] lru_tail = '0;
  logic [COUNT_W-1:0] lru_held = '0;
  logic [COUNT_W-1:0] lru_cap  = CAP_RESET;

  lru_cmd_t cmd_pend_q[$];
  lru_res_t lru_exp_q[$];
  lru_cmd_t drv_item;
  lru_res_t want;

  bit calm = 1'b0;
  int fail_cnt = 0;
  int rx_seen = 0;
  int rx_hold = 0;
  bit rx_hold_done = 1'b0;
  int wdog = 0;

  function automatic void lru_unlink(logic [FRAME_W-1:0] f);
    logic [FRAME_W-1:0] p;
    logic [FRAME_W-1:0] n;
    p = lru_prev[f];
    n = lru_next[f];
    if (lru_held <= 1) begin
      lru_head = '0;
      lru_tail = '0;
    end else begin
      if (f == lru_head) lru_head = n;
      else lru_next[p] = n;
      if (f == lru_tail) lru_tail = p;
      else lru_prev[n] = p;
    end
    lru_present[f] = 1'b0;
    if (lru_held > 0) lru_held = lru_held - 1'b1;
  endfunction

  function automatic lru_res_t lru_apply(logic [1:0] cmd, logic [FRAME_W-1:0] f);
    lru_res_t r;
    r.status = ST_NOCHG;
    r.victim = '0;
    case (cmd)
      CMD_PIN: begin
        if (lru_present[f]) begin
          lru_unlink(f);
          r.status = ST_DONE;
        end
      end
      CMD_UNPIN: begin
        if (!lru_present[f]) begin
          if (lru_held >= lru_cap) begin
            r.status = ST_FULL;
          end else begin
            if (lru_held == 0) begin
              lru_head = f;
              lru_prev[f] = '0;
            end else begin
              lru_next[lru_tail] = f;
              lru_prev[f] = lru_tail;
            end
            lru_next[f] = '0;
            lru_tail = f;
            lru_present[f] = 1'b1;
            lru_held = lru_held + 1'b1;
            r.status = ST_DONE;
          end
        end
      end
      CMD_VICTIM: begin
        if (lru_held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.victim = lru_head;
          lru_unlink(r.victim);
          r.status = ST_DONE;
        end
      end
      default: ;
    endcase
    r.count = lru_held;
    return r;
  endfunction

  task automatic queue_cmd(cmd_t c, int f);
    lru_cmd_t it;
    it.cmd = c;
    it.frame = FRAME_W'(f);
    cmd_pend_q = {cmd_pend_q, it};
  endtask

  task automatic wait_drain();
    while (cmd_pend_q.size() != 0 || in_if.valid || lru_exp_q.size() != 0) @(negedge clk);
  endtask

  task automatic set_capacity(int v);
    wait_drain();
    repeat (3) @(negedge clk);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= COUNT_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    lru_cap = COUNT_W'(v);
    @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        lru_exp_q = {lru_exp_q, lru_apply(in_if.command, in_if.frame_num)};
      end
      if (!in_if.valid || in_if.ready) begin
        if (cmd_pend_q.size() != 0 && (calm || $urandom_range(99) >= 30)) begin
          drv_item = cmd_pend_q[0];
          cmd_pend_q.delete(0);
          in_if.valid <= 1'b1;
          in_if.command <= drv_item.cmd;
          in_if.frame_num <= drv_item.frame;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        rx_seen++;
        if (lru_exp_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_cnt++;
        end else begin
          want = lru_exp_q[0];
          lru_exp_q.delete(0);
          if (out_if.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_if.status);
            fail_cnt++;
          end
          if (out_if.victim_frame !== want.victim) begin
            $error("victim_frame: expected %0d, actual %0d", want.victim, out_if.victim_frame);
            fail_cnt++;
          end
          if (out_if.count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, out_if.count);
            fail_cnt++;
          end
        end
      end
      if (!rx_hold_done && rx_seen >= STALL_AT) begin
        rx_hold_done = 1'b1;
        rx_hold = STALL_LEN;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= calm || ($urandom_range(99) >= 30);
      end
    end
  end

  // watchdog on beats of any kind
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we) begin
      wdog <= 0;
    end else if (wdog >= WDOG_MAX) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      wdog <= wdog + 1;
    end
  end

  initial begin
    int caps [8];
    int order [FRAMES];
    int unpin_pct;
    int r;
    int j;
    int tmp;
    int f;
    cmd_t c;

    in_if.valid = 1'b0;
    in_if.command = CMD_NONE;
    in_if.frame_num = '0;
    out_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    for (int i = 0; i < FRAMES; i++) begin
      lru_present[i] = 1'b0;
      lru_next[i] = '0;
      lru_prev[i] = '0;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset capacity
    queue_cmd(CMD_VICTIM, 0);
    queue_cmd(CMD_PIN, 0);
    queue_cmd(CMD_UNPIN, 0);
    queue_cmd(CMD_UNPIN, 63);
    queue_cmd(CMD_UNPIN, 63);
    queue_cmd(CMD_UNPIN, 5);
    queue_cmd(CMD_PIN, 63);
    queue_cmd(CMD_PIN, 5);
    queue_cmd(CMD_UNPIN, 63);
    queue_cmd(CMD_VICTIM, 63);
    queue_cmd(CMD_VICTIM, 0);
    queue_cmd(CMD_VICTIM, 0);
    queue_cmd(CMD_NONE, 63);
    queue_cmd(CMD_NONE, 0);
    queue_cmd(CMD_UNPIN, 1);
    queue_cmd(CMD_PIN, 1);

    // zero capacity refuses every unpin
    set_capacity(0);
    queue_cmd(CMD_UNPIN, 7);
    queue_cmd(CMD_PIN, 7);
    queue_cmd(CMD_VICTIM, 0);

    // duplicate is reported before full
    set_capacity(2);
    queue_cmd(CMD_UNPIN, 1);
    queue_cmd(CMD_UNPIN, 2);
    queue_cmd(CMD_UNPIN, 3);
    queue_cmd(CMD_UNPIN, 2);
    queue_cmd(CMD_PIN, 1);
    queue_cmd(CMD_VICTIM, 0);

    caps = '{127, 64, 1, 0, 3, 0, 127, 64};
    caps[5] = $urandom_range(127);
    for (int ph = 0; ph < 8; ph++) begin
      set_capacity(caps[ph]);
      calm = (ph == 2);
      if (ph == 0 || ph == 6) begin
        for (int i = 0; i < FRAMES; i++) order[i] = i;
        for (int i = FRAMES - 1; i > 0; i--) begin
          j = $urandom_range(i);
          tmp = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        for (int i = 0; i < FRAMES; i++) queue_cmd(CMD_UNPIN, order[i]);
      end
      unpin_pct = (ph % 2) ? 65 : 40;
      for (int n = 0; n < PH_ITEMS; n++) begin
        r = $urandom_range(99);
        f = $urandom_range(1) ? $urandom_range(7) : $urandom_range(FRAMES - 1);
        if (r < unpin_pct) c = CMD_UNPIN;
        else if (r < unpin_pct + (95 - unpin_pct) / 2) c = CMD_PIN;
        else if (r < 95) c = CMD_VICTIM;
        else c = CMD_NONE;
        queue_cmd(c, f);
      end
    end
    calm = 1'b0;

    wait_drain();
    repeat (20) @(posedge clk);
    if (fail_cnt == 0 && lru_exp_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
